FILE: design/ccb_pkg.sv
`timescale 1ns / 1ps
package ccb_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int HEIGHT_LIMIT  = 4096;
  localparam int SUM_W         = 20;   // weighted sum, signed
  localparam int DVS_W         = 17;   // either divisor, signed
  localparam logic [7:0] SAT_MAX = 8'd255;

  typedef enum logic [2:0] {
    REG_WIDTH   = 3'd0,
    REG_HEIGHT  = 3'd1,
    REG_TOP     = 3'd2,
    REG_MID     = 3'd3,
    REG_BOTTOM  = 3'd4,
    REG_DIVISOR = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic       op;
    logic [7:0] pixel;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  value;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic        frame_end;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic signed [DVS_W-1:0] divisor;
  } div_req_t;

endpackage

FILE: design/ccb_linemem.sv
`timescale 1ns / 1ps
module ccb_linemem #(
  parameter int DEPTH = ccb_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata
);
  // upper line in the high byte, lower line in the low byte
  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/ccb_div.sv
`timescale 1ns / 1ps
module ccb_div (
  input  logic                            clk,
  input  logic                            rst,
  input  ccb_pkg::div_req_t               req,
  output logic                            done,
  output logic signed [ccb_pkg::SUM_W-1:0] quotient
);
  import ccb_pkg::*;

  localparam int CNTW = $clog2(SUM_W + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [SUM_W-1:0] mag;
  logic [DVS_W-1:0] dmag;
  logic [DVS_W-1:0] rem;
  logic             neg;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem, mag[SUM_W-1]};
  assign fits  = trial >= {1'b0, dmag};
  assign quotient = neg ? -$signed(mag) : $signed(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(SUM_W);
        mag  <= req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
        dmag <= req.divisor[DVS_W-1] ? DVS_W'(-req.divisor) : DVS_W'(req.divisor);
        neg  <= req.dividend[SUM_W-1] ^ req.divisor[DVS_W-1];
        rem  <= '0;
      end else if (busy) begin
        // one quotient bit a cycle, restoring
        rem <= fits ? DVS_W'(trial - {1'b0, dmag}) : DVS_W'(trial);
        mag <= {mag[SUM_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/conv3x3_replicate_border.sv
`timescale 1ns / 1ps
// channel | signals                          | word
// --------+----------------------------------+---------------------------
// input   | in_valid, in_stall, in_word      | op, pixel
// output  | out_valid, out_stall, out_word   | value, row, col, frame_end, last
// config  | psel penable pwrite paddr pwdata | six registers at 4*i
//
// One word at a time: the line memory is read and written back, then each
// result runs 9 MAC steps, two shared divisions and the emit step.
// A word thus gives zero, one or two results.
// Reset (synchronous, rst high) clears counters, window and registers; the
// line memory is not cleared. A stalled output holds its word and the
// sequencer waits in the emit step; input is taken only when idle.
module conv3x3_replicate_border #(
  parameter int MAX_WIDTH = ccb_pkg::MAX_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ccb_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output ccb_pkg::out_word_t out_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ccb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_READ   = 8'b0000_0010,
    S_MAC    = 8'b0000_0100,
    S_START1 = 8'b0000_1000,
    S_DIV1   = 8'b0001_0000,
    S_START2 = 8'b0010_0000,
    S_DIV2   = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_t;

  // configuration registers
  logic [10:0] image_width;
  logic [12:0] image_height;
  logic [23:0] coef_top, coef_mid, coef_bottom;
  logic [15:0] divisor;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd1024;
      image_height <= 13'd768;
      coef_top     <= 24'd0;
      coef_mid     <= 24'd256;
      coef_bottom  <= 24'd0;
      divisor      <= 16'd1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_WIDTH:   image_width  <= pwdata[10:0];
        REG_HEIGHT:  image_height <= pwdata[12:0];
        REG_TOP:     coef_top     <= pwdata[23:0];
        REG_MID:     coef_mid     <= pwdata[23:0];
        REG_BOTTOM:  coef_bottom  <= pwdata[23:0];
        REG_DIVISOR: divisor      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_WIDTH:   prdata = {21'd0, image_width};
      REG_HEIGHT:  prdata = {19'd0, image_height};
      REG_TOP:     prdata = {8'd0, coef_top};
      REG_MID:     prdata = {8'd0, coef_mid};
      REG_BOTTOM:  prdata = {8'd0, coef_bottom};
      REG_DIVISOR: prdata = {16'd0, divisor};
      default:     prdata = '0;
    endcase
  end

  // clamp out-of-range geometry
  logic [12:0] w_eff, h_eff;
  always_comb begin
    if (image_width == 11'd0) w_eff = 13'd1;
    else if (13'(image_width) > 13'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
    else w_eff = 13'(image_width);
    if (image_height == 13'd0) h_eff = 13'd1;
    else if (image_height > 13'(HEIGHT_LIMIT)) h_eff = 13'(HEIGHT_LIMIT);
    else h_eff = image_height;
  end

  state_t         state;
  logic [CW-1:0]  col_count;
  logic [12:0]    row_count;
  logic [7:0]     win [3][3];
  in_word_t       item;
  logic [CW-1:0]  item_col;
  logic [12:0]    item_row;
  logic           item_fe;
  logic           need_b;
  logic           filt_b;
  logic [1:0]     mr, mc;
  logic signed [SUM_W-1:0] acc;
  logic signed [11:0]      csum;

  // line memory
  logic [15:0] rd;
  logic [7:0]  src, top_px, mid_px;
  logic        mem_we;

  ccb_linemem #(.DEPTH(MAX_WIDTH), .AW(CW)) u_mem (
    .clk   (clk),
    .raddr (col_count),
    .rdata (rd),
    .we    (mem_we),
    .waddr (item_col),
    .wdata ({mid_px, src})
  );

  assign mem_we = state == S_READ;

  always_comb begin
    src = item.op ? rd[7:0] : item.pixel;
    if (item_row == 13'd0) begin
      // top border: the first row stands in for the rows above
      top_px = src;
      mid_px = src;
    end else begin
      top_px = rd[15:8];
      mid_px = rd[7:0];
    end
  end

  logic lastcol;
  assign lastcol = (13'(item_col) + 13'd1) >= w_eff;

  // one MAC step: coefficient by window pixel
  logic [23:0]       creg;
  logic signed [7:0] coef;
  logic [1:0]        csel;
  logic signed [16:0] prod;
  always_comb begin
    unique case (mr)
      2'd0:    creg = coef_top;
      2'd1:    creg = coef_mid;
      default: creg = coef_bottom;
    endcase
    coef = $signed(creg[8*mc +: 8]);
    // right border repeats the last column
    csel = filt_b ? ((mc == 2'd0) ? 2'd1 : 2'd2) : mc;
    prod = coef * $signed({1'b0, win[mr][csel]});
  end

  // shared divider
  div_req_t dreq;
  logic     div_done;
  logic signed [SUM_W-1:0] quot;

  always_comb begin
    dreq.start    = (state == S_START1) || (state == S_START2);
    dreq.dividend = (state == S_START1) ? acc : quot;
    if (state == S_START1) begin
      dreq.divisor = (divisor == 16'd0) ? DVS_W'(1) : $signed({1'b0, divisor});
    end else begin
      dreq.divisor = (csum == 12'sd0) ? DVS_W'(1) : DVS_W'(csum);
    end
  end

  ccb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (dreq),
    .done     (div_done),
    .quotient (quot)
  );

  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      col_count <= '0;
      row_count <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) win[i][j] <= '0;
      end
    end else begin
      // drop a taken word unless the emit step refills the register
      if (out_valid && !out_stall && state != S_EMIT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item     <= in_word;
            item_col <= col_count;
            item_row <= row_count;
            state    <= S_READ;
          end
        end
        S_READ: begin
          // shift the window; column zero fills all three columns
          for (int i = 0; i < 3; i++) begin
            if (item_col == '0) begin
              win[i][0] <= (i == 0) ? top_px : (i == 1) ? mid_px : src;
              win[i][1] <= (i == 0) ? top_px : (i == 1) ? mid_px : src;
            end else begin
              win[i][0] <= win[i][1];
              win[i][1] <= win[i][2];
            end
            win[i][2] <= (i == 0) ? top_px : (i == 1) ? mid_px : src;
          end
          item_fe <= item_row >= h_eff;
          need_b  <= (item_row != 13'd0) && lastcol;
          if (lastcol) begin
            col_count <= '0;
            row_count <= (item_row >= h_eff) ? 13'd0 : item_row + 13'd1;
          end else begin
            col_count <= item_col + 1'b1;
          end
          mr   <= 2'd0;
          mc   <= 2'd0;
          acc  <= '0;
          csum <= '0;
          if (item_row != 13'd0 && item_col != '0) begin
            filt_b <= 1'b0;
            state  <= S_MAC;
          end else if (item_row != 13'd0 && lastcol) begin
            filt_b <= 1'b1;
            state  <= S_MAC;
          end else begin
            state <= S_IDLE;
          end
        end
        S_MAC: begin
          acc  <= acc + SUM_W'(prod);
          csum <= csum + 12'(coef);
          if (mc == 2'd2) begin
            mc <= 2'd0;
            mr <= mr + 2'd1;
            if (mr == 2'd2) state <= S_START1;
          end else begin
            mc <= mc + 2'd1;
          end
        end
        S_START1: state <= S_DIV1;
        S_DIV1:   if (div_done) state <= S_START2;
        S_START2: state <= S_DIV2;
        S_DIV2:   if (div_done) state <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            out_valid          <= 1'b1;
            // saturate above 255; negative results keep their low byte
            out_word.value     <= (quot > $signed(SUM_W'(SAT_MAX))) ? SAT_MAX : quot[7:0];
            out_word.out_row   <= 12'(item_row - 13'd1);
            out_word.out_col   <= filt_b ? 10'(item_col) : 10'(item_col - 1'b1);
            out_word.frame_end <= filt_b && item_fe;
            out_word.last      <= filt_b || !need_b;
            mr   <= 2'd0;
            mc   <= 2'd0;
            acc  <= '0;
            csum <= '0;
            if (!filt_b && need_b) begin
              filt_b <= 1'b1;
              state  <= S_MAC;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/ccb_checker.sv
`timescale 1ns / 1ps
module ccb_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input ccb_pkg::in_word_t  in_word,
  input logic               out_valid,
  input logic               out_stall,
  input ccb_pkg::out_word_t out_word
);
  import ccb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in work");

  a_fe_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.frame_end |-> out_word.last)
    else $error("frame end without last");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("outputs not cleared by reset");

endmodule

bind conv3x3_replicate_border ccb_checker u_chk (.*);

FILE: bench/tb_conv3x3_replicate_border.sv
`timescale 1ns / 1ps
module tb_conv3x3_replicate_border;
  import ccb_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  conv3x3_replicate_border DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Mirror of the block: registers, line stores, window and raster position.
  logic [10:0] cfg_width;
  logic [12:0] cfg_height;
  logic [23:0] cfg_coef [3];
  logic [15:0] cfg_divisor;
  logic [7:0]  store_upper [1024];
  logic [7:0]  store_lower [1024];
  bit          lower_written [1024];
  logic [7:0]  win [3][3];
  int          row_pos;
  int          col_pos;

  out_word_t   filtered_q [$];   // results still owed by the block
  out_word_t   step_out [$];     // results of the word just predicted
  int          mismatches = 0;
  bit          calm = 1'b0;      // no idling on either side while set
  int          words_sent = 0;

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic int eff_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > 1024) return 1024;
    return cfg_width;
  endfunction

  function automatic int eff_height();
    if (cfg_height == 0) return 1;
    if (cfg_height > 4096) return 4096;
    return cfg_height;
  endfunction

  // Weighted window sum over columns a, b, c, then both truncating divisions.
  function automatic logic [7:0] window_filter(input int a, input int b, input int c);
    int cols [3];
    int acc;
    int csum;
    int d;
    int wgt;
    logic signed [7:0] cf;
    cols[0] = a; cols[1] = b; cols[2] = c;
    acc = 0;
    csum = 0;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        cf = cfg_coef[i][8*k +: 8];
        wgt = cf;
        acc += wgt * int'(win[i][cols[k]]);
        csum += wgt;
      end
    end
    d = (cfg_divisor == 0) ? 1 : int'(cfg_divisor);
    acc = acc / d;
    acc = acc / ((csum != 0) ? csum : 1);
    if (acc > 255) return SAT_MAX;
    return acc[7:0];
  endfunction

  // Advance the mirror by one word and leave its results in step_out.
  function automatic void conv_predict(input in_word_t w);
    int wd;
    int ht;
    int idx;
    logic [7:0] src;
    logic [7:0] t;
    logic [7:0] m;
    logic [7:0] nv;
    bit lastcol;
    out_word_t r;
    wd = eff_width();
    ht = eff_height();
    step_out.delete();
    idx = (col_pos < 1024) ? col_pos : 1023;
    src = w.op ? store_lower[idx] : w.pixel;
    if (row_pos == 0) begin
      t = src;
      m = src;
    end else begin
      t = store_upper[idx];
      m = store_lower[idx];
    end
    store_upper[idx] = m;
    store_lower[idx] = src;
    lower_written[idx] = 1'b1;
    for (int i = 0; i < 3; i++) begin
      nv = (i == 0) ? t : (i == 1) ? m : src;
      if (col_pos == 0) begin
        win[i][0] = nv;
        win[i][1] = nv;
      end else begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[i][2] = nv;
    end
    lastcol = (col_pos + 1) >= wd;
    if (row_pos >= 1) begin
      if (col_pos >= 1) begin
        r.value = window_filter(0, 1, 2);
        r.out_row = 12'(row_pos - 1);
        r.out_col = 10'(col_pos - 1);
        r.frame_end = 1'b0;
        r.last = 1'b0;
        step_out.push_back(r);
      end
      if (lastcol) begin
        r.value = window_filter(1, 2, 2);
        r.out_row = 12'(row_pos - 1);
        r.out_col = 10'(col_pos);
        r.frame_end = (row_pos >= ht);
        r.last = 1'b0;
        step_out.push_back(r);
      end
      if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
    end
    if (lastcol) begin
      col_pos = 0;
      row_pos = (row_pos >= ht) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // Present one word after a random gap and hold it until accepted.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // APB write: setup phase, then access phase; pready is always high.
  task automatic cfg_write(input reg_idx_t r, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_WIDTH:   cfg_width   = v[10:0];
      REG_HEIGHT:  cfg_height  = v[12:0];
      REG_TOP:     cfg_coef[0] = v[23:0];
      REG_MID:     cfg_coef[1] = v[23:0];
      REG_BOTTOM:  cfg_coef[2] = v[23:0];
      REG_DIVISOR: cfg_divisor = v[15:0];
      default: ;
    endcase
  endtask

  // Drain every owed result, then let the sequencer go fully idle.
  task automatic settle();
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_all(input logic [31:0] wd, input logic [31:0] ht,
                           input logic [31:0] ct, input logic [31:0] cm,
                           input logic [31:0] cb, input logic [31:0] dv);
    cfg_write(REG_WIDTH, wd);
    cfg_write(REG_HEIGHT, ht);
    cfg_write(REG_TOP, ct);
    cfg_write(REG_MID, cm);
    cfg_write(REG_BOTTOM, cb);
    cfg_write(REG_DIVISOR, dv);
  endtask

  // One whole frame: rows of pixels, then the drain row, with a little noise.
  task automatic send_frame();
    int total;
    int pct;
    in_word_t w;
    total = (eff_height() + 1) * eff_width();
    for (int n = 0; n < total; n++) begin
      pct = (row_pos >= eff_height()) ? 85 : 8;
      w.op = ($urandom_range(0, 99) < pct) && lower_written[col_pos];
      case ($urandom_range(0, 9))
        0:       w.pixel = 8'd0;
        1:       w.pixel = 8'd255;
        default: w.pixel = 8'($urandom_range(0, 255));
      endcase
      // Hold off once in a while until every owed result is out.
      if (words_sent % 97 == 50) begin
        in_valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge clk);
      end
      send_word(w);
      conv_predict(w);
      foreach (step_out[i]) filtered_q.push_back(step_out[i]);
    end
  endtask

  function automatic logic [31:0] rand_coef_row();
    logic [31:0] v;
    v = '0;
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 2) == 0) v[8*k +: 8] = 8'($urandom_range(0, 255));
      else v[8*k +: 8] = 8'($urandom_range(0, 6) - 3);
    end
    return v;
  endfunction

  // Receiver: random stall pattern, check each accepted word.
  int stall_left = 0;
  always @(posedge clk) begin
    out_word_t e;
    if (!rst && out_valid && !out_stall) begin
      if (filtered_q.size() == 0) begin
        report($sformatf("unexpected word %h", out_word));
      end else begin
        e = filtered_q.pop_front();
        if (out_word.value !== e.value)
          report($sformatf("value %0d, expected %0d at (%0d,%0d)",
                           out_word.value, e.value, e.out_row, e.out_col));
        if (out_word.out_row !== e.out_row)
          report($sformatf("row %0d, expected %0d", out_word.out_row, e.out_row));
        if (out_word.out_col !== e.out_col)
          report($sformatf("col %0d, expected %0d", out_word.out_col, e.out_col));
        if (out_word.frame_end !== e.frame_end)
          report($sformatf("frame_end %b, expected %b at (%0d,%0d)",
                           out_word.frame_end, e.frame_end, e.out_row, e.out_col));
        if (out_word.last !== e.last)
          report($sformatf("last %b, expected %b at (%0d,%0d)",
                           out_word.last, e.last, e.out_row, e.out_col));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  typedef struct {
    logic      op;
    logic [7:0] pixel;
    int        n;      // typed results, or -1 to take the predictor's
    out_word_t e0;
    out_word_t e1;
  } stim_row_t;

  stim_row_t directed [$];

  initial begin
    stim_row_t s;
    in_word_t w;
    int phase;
    cfg_width = 11'd1024;
    cfg_height = 13'd768;
    cfg_coef[0] = 24'd0;
    cfg_coef[1] = 24'd256;
    cfg_coef[2] = 24'd0;
    cfg_divisor = 16'd1;
    row_pos = 0;
    col_pos = 0;
    foreach (win[i, k]) win[i][k] = 8'd0;
    foreach (store_lower[i]) begin
      store_lower[i] = 8'd0;
      store_upper[i] = 8'd0;
      lower_written[i] = 1'b0;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: 2x1 frame, identity kernel. Top border gives nothing,
    // the drain row brings out row 0 with the right border repeated.
    cfg_write(REG_WIDTH, 32'd2);
    cfg_write(REG_HEIGHT, 32'd1);
    directed.push_back('{1'b0, 8'd0,   0, '0, '0});
    directed.push_back('{1'b0, 8'd255, 0, '0, '0});
    directed.push_back('{1'b1, 8'd77,  0, '0, '0});
    directed.push_back('{1'b1, 8'd0,   2, '{8'd0, 12'd0, 10'd0, 1'b0, 1'b0},
                                          '{8'd255, 12'd0, 10'd1, 1'b1, 1'b1}});
    // Second frame: pixel in the drain row, drain in a frame row.
    directed.push_back('{1'b0, 8'd128, -1, '0, '0});
    directed.push_back('{1'b1, 8'd9,   -1, '0, '0});
    directed.push_back('{1'b0, 8'd1,   -1, '0, '0});
    directed.push_back('{1'b0, 8'd254, -1, '0, '0});
    foreach (directed[i]) begin
      s = directed[i];
      w.op = s.op;
      w.pixel = s.pixel;
      send_word(w);
      conv_predict(w);
      if (s.n < 0) begin
        foreach (step_out[j]) filtered_q.push_back(step_out[j]);
      end else begin
        if (s.n > 0) filtered_q.push_back(s.e0);
        if (s.n > 1) filtered_q.push_back(s.e1);
      end
    end
    in_valid <= 1'b0;
    settle();

    phase = 0;
    while (words_sent < 1650) begin
      calm = (phase % 5 == 3);
      case (phase)
        1: write_all(32'd1, 32'd1, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'd65535);
        2: write_all(32'd0, 32'd0, 32'h7F7F7F, 32'h7F7F7F, 32'h7F7F7F, 32'd0);
        4: write_all(32'd6, 32'd4, 32'h808080, 32'h000100, 32'h000000, 32'd1);
        default: write_all($urandom_range(0, 9) == 0 ? $urandom_range(9, 40)
                                                     : $urandom_range(1, 8),
                           $urandom_range(1, 6), rand_coef_row(), rand_coef_row(),
                           rand_coef_row(),
                           $urandom_range(0, 7) == 0 ? $urandom_range(0, 65535)
                                                     : $urandom_range(0, 4));
      endcase
      repeat ($urandom_range(1, 2)) send_frame();
      in_valid <= 1'b0;
      settle();
      phase++;
    end

    calm = 1'b0;
    if (filtered_q.size() != 0) report($sformatf("%0d results never came", filtered_q.size()));
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
